// File: rtl/core/run_literal_byte_encoder_defines.svh
// Assertion macros for the run/literal byte encoder.
// Included by the top level; no other dependencies.
`ifndef RUN_LITERAL_BYTE_ENCODER_DEFINES_SVH
`define RUN_LITERAL_BYTE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RLBE_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define RLBE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next-cycle implication failed");

`else

`define RLBE_ASSERT_IMPLY(label, clk, rst, cond, prop)

`define RLBE_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: rtl/core/rlbe_pkg.sv
// Shared types and constants for the run/literal byte encoder.
// No dependencies.
package rlbe_pkg;

   localparam int BYTE_W     = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_W     = BYTE_W * WORD_BYTES;
   localparam int FILL_W     = 3;
   localparam int CNT_W      = 7;
   localparam int BCNT_W     = 4;

   // input operation codes
   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // packet header codes
   localparam logic [BYTE_W-1:0] FULL_RUN_HEAD = 8'hFF;
   localparam logic [BYTE_W-1:0] RUN_WRAP      = 8'h80;

   // one packet for the back end: a pair, or a literal header plus store bytes
   typedef struct packed {
      logic               is_lit;
      logic               bank;
      logic [BYTE_W-1:0]  head;
      logic [BYTE_W-1:0]  tail;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   // back end hands a store bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

   // one packed result beat
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [BCNT_W-1:0] count;
      logic              last;
   } rsp_type;

endpackage

// File: rtl/core/run_literal_byte_encoder.sv
// Run/literal byte encoder: each input byte is compared with the one held
// before it; repeats become run packets (0x80|run or 0xFF for a full run,
// then the byte) and other bytes gather into literal packets (count header,
// then the bytes), closed by a repeat, by reaching MAX_LITERAL, or by a flush
// beat. The bytes one input causes come out packed up to eight per result
// beat, first byte in bits 7:0, with last set on the final beat of that
// input; an input that causes no bytes gives no result. The front end takes
// one input beat per cycle while the command queue has room. The back end
// loads each packet command while idle, then emits one encoded byte per
// cycle while the result queue has room; results pass through a two-beat
// output queue. The literal store has two banks: a new literal packet may
// gather while the previous one drains, and input also stalls when the
// bank it would fill is still being read out. No clearing pass is needed
// after reset.
// Depends on rlbe_pkg, rlbe_front, rlbe_back, rlbe_fifo, rlbe_ram.
`include "run_literal_byte_encoder_defines.svh"

module run_literal_byte_encoder import rlbe_pkg::*; #(
   parameter int MAX_LITERAL = 127
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_op,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [WORD_W-1:0]   rsp_data_word,
   output logic [BCNT_W-1:0]   rsp_byte_count,
   output logic                rsp_last
);

   localparam int LIT_AW    = $clog2(MAX_LITERAL);
   localparam int RAM_DEPTH = 2 ** (LIT_AW + 1);
   localparam int CMD_W     = $bits(cmd_type);
   localparam int RSP_W     = $bits(rsp_type);
   localparam int Q_DEPTH   = 2;

   cmd_type           cmd_wr;
   cmd_type           cmd_rd;
   logic [CMD_W-1:0]  cmd_rd_bits;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic              ram_we, ram_re;
   logic [LIT_AW:0]   ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_wdata, ram_rdata;
   bank_free_type     bank_free;
   rsp_type           out_data;
   rsp_type           rsp_head;
   logic [RSP_W-1:0]  rsp_head_bits;
   logic              out_push, out_full;

   // front end: classify and issue packets
   rlbe_front #(
      .MAX_LITERAL (MAX_LITERAL),
      .LIT_AW      (LIT_AW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wr),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .bank_free     (bank_free)
   );

   // command queue between the two halves
   rlbe_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (Q_DEPTH)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rd_bits),
      .empty (cmd_empty)
   );

   assign cmd_rd = cmd_type'(cmd_rd_bits);

   // two-bank literal store
   rlbe_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // back end: byte walk and word packing
   rlbe_back #(
      .MAX_LITERAL (MAX_LITERAL),
      .LIT_AW      (LIT_AW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rd),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data),
      .bank_free (bank_free)
   );

   // result queue
   rlbe_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (Q_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_head_bits),
      .empty (rsp_empty)
   );

   assign rsp_head       = rsp_type'(rsp_head_bits);
   assign rsp_data_word  = rsp_head.word;
   assign rsp_byte_count = rsp_head.count;
   assign rsp_last       = rsp_head.last;

   // checks
   `RLBE_ASSERT_IMPLY(a_bank_split, clock, reset, ram_we && ram_re, ram_waddr[LIT_AW] != ram_raddr[LIT_AW])
   `RLBE_ASSERT_IMPLY(a_cmd_room, clock, reset, cmd_push, !cmd_full)
   `RLBE_ASSERT_IMPLY(a_rsp_count, clock, reset, !rsp_empty, rsp_byte_count != 4'd0 && rsp_byte_count <= 4'd8)
   `RLBE_ASSERT_NEXT(a_packet_held, clock, reset, out_push && !out_data.last, !cmd_pop)

endmodule

// File: rtl/core/rlbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rlbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/rlbe_fifo.sv
// Small first-in first-out queue of flat words.
// No dependencies.
module rlbe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int PW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/core/rlbe_front.sv
// Front end: takes input beats, tracks run and literal state, fills the
// literal store and issues packet commands. Depends on rlbe_pkg.
module rlbe_front import rlbe_pkg::*; #(
   parameter int MAX_LITERAL = 127,
   parameter int LIT_AW      = $clog2(MAX_LITERAL)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_op,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                cmd_full,
   output logic                cmd_push,
   output cmd_type             cmd_data,
   output logic                ram_we,
   output logic [LIT_AW:0]     ram_waddr,
   output logic [BYTE_W-1:0]   ram_wdata,
   input  bank_free_type       bank_free
);

   logic [BYTE_W-1:0] held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  lit_ff, lit_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic              accept;
   logic              same;
   logic [BYTE_W-1:0] run_inc;
   logic [BYTE_W-1:0] lit_inc;
   logic              lit_full;
   logic              issue_pair;
   logic              issue_lit;
   logic [BYTE_W-1:0] pair_head;
   logic [CNT_W-1:0]  lit_n;

   // stall on a full command queue or while the fill bank is still draining
   assign req_full  = cmd_full || busy_ff[bank_ff];
   assign accept    = req_push && !req_full;
   assign same      = held_ff == req_data_byte;
   assign run_inc   = {1'b0, run_ff} + 8'd1;
   assign lit_inc   = {1'b0, lit_ff} + 8'd1;
   assign lit_full  = lit_inc >= BYTE_W'(MAX_LITERAL);
   assign ram_waddr = {bank_ff, lit_ff[LIT_AW-1:0]};
   assign ram_wdata = held_ff;

   // classify the beat against the held byte
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      run_in        = run_ff;
      lit_in        = lit_ff;
      ram_we        = 1'b0;
      issue_pair    = 1'b0;
      issue_lit     = 1'b0;
      pair_head     = FULL_RUN_HEAD;
      lit_n         = lit_inc[CNT_W-1:0];
      if (accept) begin
         unique case (req_op)
            OP_DATA: begin
               if (held_valid_ff) begin
                  if (same) begin
                     if (lit_ff != '0) begin
                        // repeat closes the pending literals
                        ram_we    = 1'b1;
                        issue_lit = 1'b1;
                        lit_in    = '0;
                        run_in    = CNT_W'(1);
                     end else if (run_inc == RUN_WRAP) begin
                        issue_pair = 1'b1;
                        pair_head  = FULL_RUN_HEAD;
                        run_in     = CNT_W'(1);
                     end else begin
                        run_in = run_inc[CNT_W-1:0];
                     end
                  end else begin
                     if (run_ff > CNT_W'(1)) begin
                        issue_pair = 1'b1;
                        pair_head  = {1'b1, run_ff};
                        run_in     = CNT_W'(1);
                     end else begin
                        ram_we = 1'b1;
                        if (lit_full) begin
                           issue_lit = 1'b1;
                           lit_in    = '0;
                           run_in    = CNT_W'(1);
                        end else begin
                           lit_in = lit_inc[CNT_W-1:0];
                        end
                     end
                  end
               end
               held_in       = req_data_byte;
               held_valid_in = 1'b1;
            end
            OP_FLUSH: begin
               if (held_valid_ff && run_ff > CNT_W'(1)) begin
                  issue_pair = 1'b1;
                  pair_head  = {1'b1, run_ff};
               end else if (held_valid_ff) begin
                  ram_we    = 1'b1;
                  issue_lit = 1'b1;
               end else if (lit_ff != '0) begin
                  issue_lit = 1'b1;
                  lit_n     = lit_ff;
               end
               held_in       = '0;
               held_valid_in = 1'b0;
               run_in        = CNT_W'(1);
               lit_in        = '0;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   // command build and bank bookkeeping
   always_comb begin
      cmd_push       = issue_pair || issue_lit;
      cmd_data       = '0;
      cmd_data.tail  = held_ff;
      if (issue_lit) begin
         cmd_data.is_lit = 1'b1;
         cmd_data.bank   = bank_ff;
         cmd_data.head   = {1'b0, lit_n};
         cmd_data.count  = lit_n;
      end else begin
         cmd_data.head   = pair_head;
      end
      busy_in = busy_ff;
      bank_in = bank_ff;
      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end
      if (issue_lit) begin
         busy_in[bank_ff] = 1'b1;
         bank_in          = ~bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         run_ff        <= CNT_W'(1);
         lit_ff        <= '0;
         bank_ff       <= 1'b0;
         busy_ff       <= '0;
      end else begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         run_ff        <= run_in;
         lit_ff        <= lit_in;
         bank_ff       <= bank_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

// File: rtl/core/rlbe_back.sv
// Back end: walks one packet command a byte per cycle while the result queue
// has room, reads literal store bytes, packs result words. Depends on rlbe_pkg.
module rlbe_back import rlbe_pkg::*; #(
   parameter int MAX_LITERAL = 127,
   parameter int LIT_AW      = $clog2(MAX_LITERAL)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  cmd_type           cmd_data,
   output logic              ram_re,
   output logic [LIT_AW:0]   ram_raddr,
   input  logic [BYTE_W-1:0] ram_rdata,
   input  logic              out_full,
   output logic              out_push,
   output rsp_type           out_data,
   output bank_free_type     bank_free
);

   logic              active_ff, active_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [WORD_W-1:0] word_ff, word_in;

   logic              advance;
   logic              last_byte;
   logic              word_done;
   logic [CNT_W-1:0]  last_pos;
   logic [BYTE_W-1:0] cur_byte;
   logic [WORD_W-1:0] word_next;

   assign advance   = active_ff && !out_full;
   assign last_pos  = cmd_ff.is_lit ? cmd_ff.count : CNT_W'(1);
   assign last_byte = pos_ff == last_pos;
   assign word_done = last_byte || (fill_ff == FILL_W'(WORD_BYTES - 1));
   assign cmd_pop   = !active_ff && !cmd_empty;

   // byte source: header, then store bytes or the pair's second byte
   always_comb begin
      priority if (pos_ff == '0) begin
         cur_byte = cmd_ff.head;
      end else if (cmd_ff.is_lit) begin
         cur_byte = ram_rdata;
      end else begin
         cur_byte = cmd_ff.tail;
      end
   end

   // drop the byte into its lane
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         word_next[i*BYTE_W +: BYTE_W] = (fill_ff == FILL_W'(i)) ? cur_byte
                                                             : word_ff[i*BYTE_W +: BYTE_W];
      end
   end

   // result beat and store read one byte ahead
   always_comb begin
      out_push       = advance && word_done;
      out_data.word  = word_next;
      out_data.count = BCNT_W'({1'b0, fill_ff} + 4'd1);
      out_data.last  = last_byte;
      ram_re         = advance && cmd_ff.is_lit && !last_byte;
      ram_raddr      = {cmd_ff.bank, pos_ff[LIT_AW-1:0]};
      bank_free.valid = advance && last_byte && cmd_ff.is_lit;
      bank_free.bank  = cmd_ff.bank;
   end

   // sequencing
   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      fill_in   = fill_ff;
      word_in   = word_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         cmd_in    = cmd_data;
         pos_in    = '0;
         fill_in   = '0;
         word_in   = '0;
      end else if (advance) begin
         pos_in = CNT_W'(pos_ff + 1'b1);
         if (word_done) begin
            fill_in = '0;
            word_in = '0;
         end else begin
            fill_in = FILL_W'(fill_ff + 1'b1);
            word_in = word_next;
         end
         if (last_byte) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         fill_ff   <= '0;
         word_ff   <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         fill_ff   <= fill_in;
         word_ff   <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for run_literal_byte_encoder: byte streams go in,
// packed run/literal packets come out and are checked beat by beat.
// Depends on rlbe_pkg and the run_literal_byte_encoder RTL.
module testbench;
   import rlbe_pkg::*;

   localparam int MAX_LIT     = 127;
   localparam int DRAIN_TICKS = 300;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_push       = 1'b0;
   logic                req_op         = OP_DATA;
   logic [BYTE_W-1:0]   req_data_byte  = '0;
   logic                rsp_pop        = 1'b0;
   logic                req_full;
   logic                rsp_empty;
   logic [WORD_W-1:0]   rsp_data_word;
   logic [BCNT_W-1:0]   rsp_byte_count;
   logic                rsp_last;

   // encoder state mirror
   logic [BYTE_W-1:0]   hold_byte;
   logic                hold_ok;
   logic [7:0]          run_len;
   logic [CNT_W-1:0]    lit_len;
   logic [BYTE_W-1:0]   lit_buf [128];
   logic [BYTE_W-1:0]   packet_bytes [$];
   rsp_type             pending_words [$];

   // traffic shaping and bookkeeping
   int                  idle_pct      = 0;
   int                  stall_pct     = 0;
   int                  items_sent    = 0;
   int                  error_count   = 0;
   logic [BYTE_W-1:0]   last_byte     = '0;

   run_literal_byte_encoder #(
      .MAX_LITERAL(MAX_LIT)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data_word  (rsp_data_word),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // literal packet: count header, then the gathered bytes
   function automatic void emit_literals(input int unsigned n);
      packet_bytes.push_back(n[7:0]);
      for (int i = 0; i < n; i++)
         packet_bytes.push_back(lit_buf[i]);
   endfunction

   // held byte repeats
   function automatic void on_repeat(input logic [BYTE_W-1:0] h);
      if (lit_len > 0) begin
         lit_buf[lit_len] = h;
         emit_literals(lit_len + 1);
         lit_len = '0;
         run_len = 8'd1;
      end else begin
         run_len = run_len + 8'd1;
         if (run_len >= 8'h80) begin
            packet_bytes.push_back(FULL_RUN_HEAD);
            packet_bytes.push_back(h);
            run_len = 8'd1;
         end
      end
   endfunction

   // held byte differs from its successor
   function automatic void on_change(input logic [BYTE_W-1:0] h);
      if (run_len > 1) begin
         packet_bytes.push_back(RUN_WRAP | run_len);
         packet_bytes.push_back(h);
         run_len = 8'd1;
      end else if (lit_len + 1 >= MAX_LIT) begin
         lit_buf[lit_len] = h;
         emit_literals(lit_len + 1);
         lit_len = '0;
         run_len = 8'd1;
      end else begin
         lit_buf[lit_len] = h;
         lit_len = lit_len + 1'b1;
      end
   endfunction

   // advance the mirror by one accepted beat and queue the packed words
   function automatic void predict_words(input logic op, input logic [BYTE_W-1:0] b);
      rsp_type w;
      int      n;
      packet_bytes.delete();
      if (op == OP_DATA) begin
         if (hold_ok) begin
            if (hold_byte == b)
               on_repeat(hold_byte);
            else
               on_change(hold_byte);
         end
         hold_byte = b;
         hold_ok   = 1'b1;
      end else begin
         if (hold_ok)
            on_change(hold_byte);
         if (lit_len > 0)
            emit_literals(lit_len);
         hold_byte = '0;
         hold_ok   = 1'b0;
         run_len   = 8'd1;
         lit_len   = '0;
      end
      for (int base = 0; base < packet_bytes.size(); base += WORD_BYTES) begin
         n = packet_bytes.size() - base;
         if (n > WORD_BYTES)
            n = WORD_BYTES;
         w.word = '0;
         for (int i = 0; i < n; i++)
            w.word[BYTE_W*i +: BYTE_W] = packet_bytes[base + i];
         w.count = n[BCNT_W-1:0];
         w.last  = (base + WORD_BYTES >= packet_bytes.size());
         pending_words.push_back(w);
      end
   endfunction

   // drive one input beat, with random idle cycles ahead of it
   task automatic send_beat(input logic op, input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct)
            @(posedge clock);
      end
      req_push      <= 1'b1;
      req_op        <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_words(op, b);
      items_sent++;
      if (op == OP_DATA)
         last_byte = b;
   endtask

   // random receiver stalls and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_words.size() == 0) begin
               $error("unexpected result beat: data_word %h", rsp_data_word);
               error_count++;
            end else begin
               if (rsp_data_word !== pending_words[0].word) begin
                  $error("data_word: expected %h, got %h",
                         pending_words[0].word, rsp_data_word);
                  error_count++;
               end
               if (rsp_byte_count !== pending_words[0].count) begin
                  $error("byte_count: expected %0d, got %0d",
                         pending_words[0].count, rsp_byte_count);
                  error_count++;
               end
               if (rsp_last !== pending_words[0].last) begin
                  $error("last: expected %0d, got %0d",
                         pending_words[0].last, rsp_last);
                  error_count++;
               end
               void'(pending_words.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // first byte, empty flush, repeats, literal closed by a repeat
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send_beat(OP_FLUSH, 8'h00);
      send_beat(OP_DATA, 8'h00);
      send_beat(OP_FLUSH, 8'hA5);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_DATA, 8'hFF);
      send_beat(OP_FLUSH, 8'hFF);
      send_beat(OP_DATA, 8'h12);
      send_beat(OP_DATA, 8'h34);
      send_beat(OP_DATA, 8'h34);
      send_beat(OP_DATA, 8'h34);
      send_beat(OP_DATA, 8'h56);
      send_beat(OP_FLUSH, 8'h5A);
      send_beat(OP_DATA, 8'h80);
      send_beat(OP_DATA, 8'h80);
      send_beat(OP_DATA, 8'h80);
      send_beat(OP_DATA, 8'h7F);
      send_beat(OP_DATA, 8'h01);
      send_beat(OP_FLUSH, 8'h00);
      send_beat(OP_FLUSH, 8'hFF);
   endtask

   // longest literal packet and run wrap at 128
   task automatic test_limits();
      logic [BYTE_W-1:0] b;
      idle_pct  = 30;
      stall_pct = 30;
      b = BYTE_W'($urandom_range(0, 255));
      repeat (129) begin
         b = b + BYTE_W'($urandom_range(1, 255));
         send_beat(OP_DATA, b);
      end
      send_beat(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
      b = BYTE_W'($urandom_range(0, 255));
      repeat (130)
         send_beat(OP_DATA, b);
      send_beat(OP_DATA, b + 8'd1);
      send_beat(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
   endtask

   // mostly well-formed runs and literal stretches, plus noise and flushes
   task automatic random_stream(input int n);
      int                start;
      int                kind;
      int                len;
      logic [BYTE_W-1:0] b;
      start = items_sent;
      while (items_sent - start < n) begin
         kind = $urandom_range(0, 9);
         len  = $urandom_range(1, 12);
         if (kind <= 3) begin
            b = BYTE_W'($urandom_range(0, 255));
            repeat (len + 1)
               send_beat(OP_DATA, b);
         end else if (kind <= 6) begin
            b = last_byte;
            repeat (len) begin
               b = b + BYTE_W'($urandom_range(1, 255));
               send_beat(OP_DATA, b);
            end
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(1))
                  b = BYTE_W'($urandom_range(0, 3));
               else
                  b = BYTE_W'($urandom_range(0, 255));
               send_beat(OP_DATA, b);
            end
         end else begin
            send_beat(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_no_idling();
      idle_pct  = 0;
      stall_pct = 0;
      random_stream(42);
   endtask

   task automatic test_sender_idle();
      idle_pct  = 85;
      stall_pct = 0;
      random_stream(42);
   endtask

   task automatic test_receiver_stall();
      idle_pct  = 0;
      stall_pct = 85;
      random_stream(42);
   endtask

   task automatic test_both_idle();
      idle_pct  = 30;
      stall_pct = 30;
      random_stream(42);
   endtask

   initial begin
      hold_byte = '0;
      hold_ok   = 1'b0;
      run_len   = 8'd1;
      lit_len   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      send_beat(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
      req_push <= 1'b0;
      // wait out the remaining results, then a quiet stretch
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hang guard
   initial begin
      #40000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
